>>> rtl/accumulator_machine_execute_macros.svh
// ----------------------------------------------------------------------------
// accumulator_machine_execute_macros
// Assertion macros for the accumulator machine execute unit.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTE_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_MACROS_SVH
`define AME_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define AME_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/ame_pkg.sv
// ----------------------------------------------------------------------------
// ame_pkg
// Types and constants shared by the accumulator machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ame_pkg;
   localparam int WORD_W = 32;
   localparam int ADDR_W = 7;
   localparam int FUNC_W = 4;
   localparam int ERR_W  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_READ = 4'd0, FN_WRITE = 4'd1, FN_LOAD = 4'd2, FN_STORE = 4'd3,
      FN_ADD = 4'd4, FN_SUB = 4'd5, FN_DIV = 4'd6, FN_MUL = 4'd7,
      FN_BR = 4'd8, FN_BRNEG = 4'd9, FN_BRZERO = 4'd10, FN_HALT = 4'd11
   } func_type;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MUL, ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;   // write zero at clear pointer
      logic capture;      // latch request, issue memory read
      logic exec;         // execute ops and div/mul launch
      logic div_step;     // one quotient bit
      logic mul_finish;   // saturate product
      logic div_finish;   // saturate quotient
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_div;       // divide launched this exec
      logic is_mul;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] write_value;
      logic                     write_valid;
      logic signed [WORD_W-1:0] acc_value;
      logic [ADDR_W-1:0]        next_counter;
      logic [ERR_W-1:0]         error_code;
      logic                     halted;
   } rsp_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] read_value;
   } req_type;
endpackage
`default_nettype wire

>>> rtl/ame_if.sv
// ----------------------------------------------------------------------------
// ame_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface ame_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ame_ctrl.sv
// ----------------------------------------------------------------------------
// ame_ctrl
// Sequencer: clear sweep, instruction fetch, execute, multi-cycle ops, output.
// ----------------------------------------------------------------------------
`default_nettype none
module ame_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ame_pkg::cmd_type         cmd,
   input  wire ame_pkg::status_type sts
);
   ame_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ame_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ame_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ame_pkg::ST_IDLE;
         end
         ame_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ame_pkg::ST_READ;
            end
         end
         ame_pkg::ST_READ: state_in = ame_pkg::ST_EXEC;
         ame_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.is_div) state_in = ame_pkg::ST_DIV;
            else if (sts.is_mul) state_in = ame_pkg::ST_MUL;
            else state_in = ame_pkg::ST_DONE;
         end
         ame_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.div_finish = 1'b1;
               state_in = ame_pkg::ST_DONE;
            end
         end
         ame_pkg::ST_MUL: begin
            cmd.mul_finish = 1'b1;
            state_in = ame_pkg::ST_DONE;
         end
         ame_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ame_pkg::ST_IDLE;
         end
         default: state_in = ame_pkg::ST_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/ame_dpath.sv
// ----------------------------------------------------------------------------
// ame_dpath
// Word memory, accumulator, counter, restoring divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module ame_dpath #(
   parameter int MEM_WORDS = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ame_pkg::req_type     req_data,
   input  wire ame_pkg::cmd_type     cmd,
   output ame_pkg::status_type       sts,
   output ame_pkg::rsp_type          rsp_data
);
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int W  = ame_pkg::WORD_W;
   localparam int DW = 2 * W;        // dividend magnitude |acc| << 16
   localparam int CW = $clog2(DW + 1);
   localparam logic [ame_pkg::ADDR_W:0] MEM_LIM = (ame_pkg::ADDR_W + 1)'(MEM_WORDS);
   localparam logic signed [DW-1:0] Q_MAX = DW'(64'sh7FFFFFFF);
   localparam logic signed [DW-1:0] Q_MIN = -DW'(64'sh80000000);

   logic signed [W-1:0] mem [MEM_WORDS];
   logic signed [W-1:0] mword_ff;
   logic [AW-1:0]       clr_ff;

   ame_pkg::req_type    req_ff;
   logic signed [W-1:0] acc_ff;
   logic [ame_pkg::ADDR_W-1:0] pc_ff;
   logic                halt_ff;
   logic                wvalid_ff;
   logic signed [W-1:0] wval_ff;
   logic [ame_pkg::ERR_W-1:0] err_ff;

   logic [DW-1:0]  quo_ff, rem_ff;
   logic [W-1:0]   dsr_ff;
   logic           neg_ff;
   logic [CW-1:0]  cnt_ff;
   logic signed [DW-1:0] prod_ff;

   logic [AW-1:0] addr_idx;
   logic in_range;
   logic [ame_pkg::ADDR_W-1:0] pc_inc;
   logic signed [W:0] addsub;
   logic [DW-1:0] rem_sh, rem_try;
   logic [DW-1:0] qmag;
   logic signed [DW-1:0] qsigned;
   logic [W-1:0] acc_mag, m_mag;

   assign addr_idx = AW'(req_ff.address);
   assign in_range = {1'b0, req_ff.address} < MEM_LIM;
   assign pc_inc   = pc_ff + 1'b1;
   assign acc_mag  = acc_ff[W-1] ? W'(-acc_ff) : W'(acc_ff);
   assign m_mag    = mword_ff[W-1] ? W'(-mword_ff) : W'(mword_ff);

   always_comb begin
      if (req_ff.func == ame_pkg::FN_SUB) addsub = {acc_ff[W-1], acc_ff} - {mword_ff[W-1], mword_ff};
      else addsub = {acc_ff[W-1], acc_ff} + {mword_ff[W-1], mword_ff};
   end

   // restoring divide, one quotient bit per cycle
   assign rem_sh  = {rem_ff[DW-2:0], quo_ff[DW-1]};
   assign rem_try = rem_sh - DW'(dsr_ff);
   always_comb begin
      qmag = {quo_ff[DW-2:0], rem_sh >= DW'(dsr_ff)};
      qsigned = neg_ff ? -$signed(qmag) : $signed(qmag);
   end

   assign sts.clear_done = (clr_ff == AW'(MEM_WORDS - 1));
   assign sts.div_done   = (cnt_ff == CW'(DW - 1));
   assign sts.is_div = !halt_ff && in_range && req_ff.func == ame_pkg::FN_DIV
                       && mword_ff != '0;
   assign sts.is_mul = !halt_ff && in_range && req_ff.func == ame_pkg::FN_MUL;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.exec && !halt_ff && in_range) begin
         if (req_ff.func == ame_pkg::FN_READ) mem[addr_idx] <= req_ff.read_value;
         else if (req_ff.func == ame_pkg::FN_STORE) mem[addr_idx] <= acc_ff;
      end
      mword_ff <= mem[addr_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step && !sts.clear_done) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.exec) begin
         rem_ff  <= '0;
         quo_ff  <= {acc_mag, 16'd0, {(DW-W-16){1'b0}}} >> (DW - W - 16);
         dsr_ff  <= m_mag;
         neg_ff  <= acc_ff[W-1] ^ mword_ff[W-1];
         cnt_ff  <= '0;
         // 32x32 signed product, full 64-bit result
         prod_ff <= acc_ff * mword_ff;
      end else if (cmd.div_step) begin
         rem_ff <= (rem_sh >= DW'(dsr_ff)) ? rem_try : rem_sh;
         quo_ff <= qmag;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; pc_ff <= '0; halt_ff <= 1'b0;
         wvalid_ff <= 1'b0; wval_ff <= '0; err_ff <= ame_pkg::ERR_NONE;
      end else if (cmd.exec) begin
         wvalid_ff <= 1'b0;
         wval_ff   <= '0;
         err_ff    <= ame_pkg::ERR_NONE;
         if (!halt_ff && req_ff.func <= ame_pkg::FN_HALT) begin
            if (req_ff.func == ame_pkg::FN_HALT) halt_ff <= 1'b1;
            else if (!in_range) err_ff <= ame_pkg::ERR_RANGE;
            else begin
               case (req_ff.func)
                  ame_pkg::FN_READ, ame_pkg::FN_LOAD, ame_pkg::FN_WRITE,
                  ame_pkg::FN_STORE, ame_pkg::FN_ADD, ame_pkg::FN_SUB: begin
                     pc_ff <= pc_inc;
                     if (req_ff.func == ame_pkg::FN_WRITE) begin
                        wvalid_ff <= 1'b1; wval_ff <= mword_ff;
                     end
                     if (req_ff.func == ame_pkg::FN_LOAD) acc_ff <= mword_ff;
                     if (req_ff.func == ame_pkg::FN_STORE) acc_ff <= '0;
                     if (req_ff.func == ame_pkg::FN_ADD || req_ff.func == ame_pkg::FN_SUB)
                        acc_ff <= (addsub[W] != addsub[W-1])
                           ? {addsub[W], {(W-1){~addsub[W]}}} : addsub[W-1:0];
                  end
                  ame_pkg::FN_DIV: begin
                     if (mword_ff == '0) err_ff <= ame_pkg::ERR_DIV0;
                     else pc_ff <= pc_inc;
                  end
                  ame_pkg::FN_MUL: pc_ff <= pc_inc;
                  ame_pkg::FN_BR: pc_ff <= req_ff.address;
                  ame_pkg::FN_BRNEG: pc_ff <= acc_ff[W-1] ? req_ff.address : pc_inc;
                  ame_pkg::FN_BRZERO: pc_ff <= (acc_ff == '0) ? req_ff.address : pc_inc;
                  default: pc_ff <= pc_ff;
               endcase
            end
         end
      end else if (cmd.mul_finish) begin
         // arithmetic shift floors toward minus infinity
         if ((prod_ff >>> 16) > Q_MAX) acc_ff <= Q_MAX[W-1:0];
         else if ((prod_ff >>> 16) < Q_MIN) acc_ff <= Q_MIN[W-1:0];
         else acc_ff <= W'(prod_ff >>> 16);
      end else if (cmd.div_finish) begin
         if (qsigned > Q_MAX) acc_ff <= Q_MAX[W-1:0];
         else if (qsigned < Q_MIN) acc_ff <= Q_MIN[W-1:0];
         else acc_ff <= qsigned[W-1:0];
      end
   end

   assign rsp_data.write_value  = wval_ff;
   assign rsp_data.write_valid  = wvalid_ff;
   assign rsp_data.acc_value    = acc_ff;
   assign rsp_data.next_counter = pc_ff;
   assign rsp_data.error_code   = err_ff;
   assign rsp_data.halted       = halt_ff;
endmodule
`default_nettype wire

>>> rtl/accumulator_machine_execute.sv
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Executes one decoded instruction per request on memory, acc and counter.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | func, address, read_value
//  rsp     | out | write_value, write_valid, acc_value, next_counter,
//          |     | error_code, halted
// One instruction at a time. An item passes through accept, memory read,
// execute and result transfer; mul adds a saturation step, and div adds a
// bit-serial divider that produces one quotient bit per step.
// After reset a clearing pass zeroes all MEM_WORDS words; req_ready is low.
// The result holds in rsp until taken; the next request waits for that.
`default_nettype none
`include "accumulator_machine_execute_macros.svh"
module accumulator_machine_execute #(
   parameter int MEM_WORDS = 100
) (
   input wire logic clock,
   input wire logic reset,
   ame_if.sink      req,
   ame_if.source    rsp
);
   ame_pkg::cmd_type    cmd;
   ame_pkg::status_type sts;

   ame_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .sts
   );

   ame_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
      .clock, .reset, .req_data(req.data), .cmd, .sts, .rsp_data(rsp.data)
   );

   `AME_ASSERT_IMPL(a_no_overlap, clock, reset, req.ready, !rsp.valid, "req with rsp pending")
   `AME_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, !req.ready, "accepted twice")
   `AME_ASSERT_IMPL(a_err_range, clock, reset, rsp.valid, rsp.data.error_code <= ame_pkg::ERR_RANGE, "bad error code")
endmodule
`default_nettype wire
